// ----- rtl/gact_pkg.sv -----
// ----------------------------------------------------------------------------
// gact_pkg
// Shared types, constants and helpers for the glyph atlas texcoord block.
// ----------------------------------------------------------------------------
`default_nettype none
package gact_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 25 + FRAC_BITS;
  localparam int SUM_W     = NUM_W + 2;
  localparam int IDX_W     = 16;
  localparam int TEX_W     = 18;
  localparam int ADDR_W    = 5;

  // Cells per divider chain and pipeline positions.
  localparam int S1_CELLS  = IDX_W;
  localparam int S2_CELLS  = IDX_W;
  localparam int MID_POS   = S1_CELLS + S2_CELLS;
  localparam int S3_CELLS  = NUM_W;
  localparam int LAST_POS  = MID_POS + S3_CELLS;
  localparam int SIDE_LEN  = LAST_POS + 1;
  localparam int SHEET_LEN = LAST_POS + 1 - S1_CELLS;

  localparam logic [2:0] REG_PER_SHEET = 3'd0;
  localparam logic [2:0] REG_PER_LINE  = 3'd1;
  localparam logic [2:0] REG_CELL_W    = 3'd2;
  localparam logic [2:0] REG_CELL_H    = 3'd3;
  localparam logic [2:0] REG_SHEET_W   = 3'd4;
  localparam logic [2:0] REG_SHEET_H   = 3'd5;

  localparam logic signed [SUM_W-1:0] TEX_MAX  = SUM_W'(131071);
  localparam logic signed [SUM_W-1:0] TEX_MIN  = -SUM_W'(131072);
  localparam logic signed [SUM_W-1:0] ONE_FIX  = SUM_W'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic        valid;
    logic [NUM_W-1:0] num;
    logic [15:0] rem;
    logic [15:0] den;
  } div_lane_t;

  typedef struct packed {
    logic [15:0] per_sheet;
    logic [7:0]  per_line;
    logic [7:0]  cell_w;
    logic [7:0]  cell_h;
    logic [10:0] sheet_w;
    logic [10:0] sheet_h;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] bearing;
    logic [7:0]        drawn_width;
    logic [7:0]        advance;
  } side_t;

  function automatic logic signed [TEX_W-1:0] sat_tex(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (c > TEX_MAX) c = TEX_MAX;
    if (c < TEX_MIN) c = TEX_MIN;
    return c[TEX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gact_if.sv -----
// ----------------------------------------------------------------------------
// gact_if
// Valid/ready channels for glyph requests and texcoord results.
// ----------------------------------------------------------------------------
`default_nettype none
interface gact_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       glyph_index;
  logic signed [7:0] bearing;
  logic [7:0]        drawn_width;
  logic [7:0]        advance;
  modport source (output valid, glyph_index, bearing, drawn_width, advance, input ready);
  modport sink   (input valid, glyph_index, bearing, drawn_width, advance, output ready);
endinterface

interface gact_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        sheet_id;
  logic signed [7:0]  x_offset;
  logic [7:0]         image_width;
  logic signed [17:0] tex_left;
  logic signed [17:0] tex_top;
  logic signed [17:0] tex_right;
  logic signed [17:0] tex_bottom;
  logic [7:0]         pen_advance;
  modport source (output valid, sheet_id, x_offset, image_width, tex_left, tex_top,
                  tex_right, tex_bottom, pen_advance, input ready);
  modport sink   (input valid, sheet_id, x_offset, image_width, tex_left, tex_top,
                  tex_right, tex_bottom, pen_advance, output ready);
endinterface
`default_nettype wire

// ----- rtl/gact_div_cell.sv -----
// ----------------------------------------------------------------------------
// gact_div_cell
// One restoring-division step: shifts in one dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module gact_div_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire gact_pkg::div_lane_t lane_i,
  output gact_pkg::div_lane_t      lane_o
);
  gact_pkg::div_lane_t lane_r, lane_nxt;
  logic [16:0] rem_s;
  logic [16:0] diff;
  logic        qbit;

  always_comb begin
    rem_s = {lane_i.rem, lane_i.num[gact_pkg::NUM_W-1]};
    diff  = rem_s - {1'b0, lane_i.den};
    qbit  = (rem_s >= {1'b0, lane_i.den});
    lane_nxt       = lane_i;
    lane_nxt.num   = {lane_i.num[gact_pkg::NUM_W-2:0], qbit};
    lane_nxt.rem   = qbit ? diff[15:0] : rem_s[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r.num <= lane_nxt.num;
      lane_r.rem <= lane_nxt.rem;
      lane_r.den <= lane_nxt.den;
    end
  end

  assign lane_o = lane_r;
endmodule
`default_nettype wire

// ----- rtl/gact_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gact_cfg_regs
// APB register file for the atlas geometry; zero divisors read as one downstream.
// ----------------------------------------------------------------------------
`default_nettype none
module gact_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gact_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output gact_pkg::cfg_t                   cfg
);
  logic [15:0] per_sheet_r;
  logic [7:0]  per_line_r, cell_w_r, cell_h_r;
  logic [10:0] sheet_w_r, sheet_h_r;
  logic        wr;
  logic [2:0]  sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_sheet_r <= 16'd1;
      per_line_r  <= 8'd1;
      cell_w_r    <= 8'd0;
      cell_h_r    <= 8'd0;
      sheet_w_r   <= 11'd256;
      sheet_h_r   <= 11'd256;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (sel)
        gact_pkg::REG_PER_SHEET: per_sheet_r <= pwdata[15:0];
        gact_pkg::REG_PER_LINE:  per_line_r  <= pwdata[7:0];
        gact_pkg::REG_CELL_W:    cell_w_r    <= pwdata[7:0];
        gact_pkg::REG_CELL_H:    cell_h_r    <= pwdata[7:0];
        gact_pkg::REG_SHEET_W:   sheet_w_r   <= pwdata[10:0];
        gact_pkg::REG_SHEET_H:   sheet_h_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      gact_pkg::REG_PER_SHEET: prdata = {16'd0, per_sheet_r};
      gact_pkg::REG_PER_LINE:  prdata = {24'd0, per_line_r};
      gact_pkg::REG_CELL_W:    prdata = {24'd0, cell_w_r};
      gact_pkg::REG_CELL_H:    prdata = {24'd0, cell_h_r};
      gact_pkg::REG_SHEET_W:   prdata = {21'd0, sheet_w_r};
      gact_pkg::REG_SHEET_H:   prdata = {21'd0, sheet_h_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.per_sheet = (per_sheet_r == 16'd0) ? 16'd1 : per_sheet_r;
    cfg.per_line  = (per_line_r == 8'd0) ? 8'd1 : per_line_r;
    cfg.cell_w    = cell_w_r;
    cfg.cell_h    = cell_h_r;
    cfg.sheet_w   = (sheet_w_r == 11'd0) ? 11'd1 : sheet_w_r;
    cfg.sheet_h   = (sheet_h_r == 11'd0) ? 11'd1 : sheet_h_r;
  end
endmodule
`default_nettype wire

// ----- rtl/glyph_atlas_cell_texcoords.sv -----
// ----------------------------------------------------------------------------
// glyph_atlas_cell_texcoords
// Splits a glyph index into sheet, line and column and gives its texel rectangle.
// ----------------------------------------------------------------------------
// Usage: glyph requests arrive on in_ch (valid/ready), one result per request
// leaves on out_ch. Geometry is set through the APB port at cfg_ and must be
// written while no glyph is in flight.
// The datapath is a row of division cells, one quotient bit per cell: 16 cells
// for index / glyphs_per_sheet, 16 for the remainder / glyphs_per_line, one
// multiply register, then FRAC_BITS+25 cells (41 at the default) running four
// fixed-point divides side by side, and an output register.
// That is 16 + 16 + 1 + (FRAC_BITS+25) + 1 register stages, 75 at the default.
// Throughput is one glyph per cycle unless the receiver stalls; every cell is
// one register stage.
// A transfer into in_ch can happen whenever the output register is empty or
// is being drained. When the receiver stalls, the whole row of cells holds
// and in_ch.ready drops, so nothing is lost.
// Reset clears all valid bits and loads the register defaults; payload is
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module glyph_atlas_cell_texcoords (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  gact_in_if.sink                          in_ch,
  gact_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [gact_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  localparam int NW = gact_pkg::NUM_W;
  localparam int FB = gact_pkg::FRAC_BITS;

  gact_pkg::cfg_t cfg;
  logic adv;

  gact_cfg_regs u_cfg (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg(cfg)
  );

  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Side payload travels alongside the cells.
  gact_pkg::side_t side_r [gact_pkg::SIDE_LEN];
  logic [15:0]     sheet_r [gact_pkg::SHEET_LEN];

  gact_pkg::div_lane_t s1 [gact_pkg::S1_CELLS+1];
  gact_pkg::div_lane_t s2 [gact_pkg::S2_CELLS+1];
  gact_pkg::div_lane_t s3 [4][gact_pkg::S3_CELLS+1];

  always_comb begin
    s1[0].valid = in_ch.valid;
    s1[0].num   = {in_ch.glyph_index, {(NW-16){1'b0}}};
    s1[0].rem   = 16'd0;
    s1[0].den   = cfg.per_sheet;
    s2[0].valid = s1[gact_pkg::S1_CELLS].valid;
    s2[0].num   = {s1[gact_pkg::S1_CELLS].rem, {(NW-16){1'b0}}};
    s2[0].rem   = 16'd0;
    s2[0].den   = {8'd0, cfg.per_line};
  end

  genvar g, l;
  generate
    for (g = 0; g < gact_pkg::S1_CELLS; g++) begin : g_s1
      gact_div_cell u_c (.clk, .rst_n, .en(adv), .lane_i(s1[g]), .lane_o(s1[g+1]));
    end
    for (g = 0; g < gact_pkg::S2_CELLS; g++) begin : g_s2
      gact_div_cell u_c (.clk, .rst_n, .en(adv), .lane_i(s2[g]), .lane_o(s2[g+1]));
    end
  endgenerate

  // Multiply stage: cell origins in texels.
  logic             mid_valid_r;
  logic [16:0]      num_x_r;
  logic [24:0]      num_y_r;
  logic [15:0]      line_w;
  logic [7:0]       col_w;

  assign line_w = s2[gact_pkg::S2_CELLS].num[15:0];
  assign col_w  = s2[gact_pkg::S2_CELLS].rem[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (adv) begin
      mid_valid_r <= s2[gact_pkg::S2_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_x_r <= {9'd0, col_w} * ({9'd0, cfg.cell_w} + 17'd1) + 17'd1;
      num_y_r <= {9'd0, line_w} * ({17'd0, cfg.cell_h} + 25'd1) + 25'd1;
    end
  end

  always_comb begin
    s3[0][0].valid = mid_valid_r;
    s3[0][0].rem   = 16'd0;
    s3[0][0].num   = NW'(num_x_r) << FB;
    s3[0][0].den   = {5'd0, cfg.sheet_w};
    s3[1][0].valid = mid_valid_r;
    s3[1][0].rem   = 16'd0;
    s3[1][0].num   = NW'(side_r[gact_pkg::MID_POS].drawn_width) << FB;
    s3[1][0].den   = {5'd0, cfg.sheet_w};
    s3[2][0].valid = mid_valid_r;
    s3[2][0].rem   = 16'd0;
    s3[2][0].num   = NW'(num_y_r) << FB;
    s3[2][0].den   = {5'd0, cfg.sheet_h};
    s3[3][0].valid = mid_valid_r;
    s3[3][0].rem   = 16'd0;
    s3[3][0].num   = NW'(cfg.cell_h) << FB;
    s3[3][0].den   = {5'd0, cfg.sheet_h};
  end

  generate
    for (l = 0; l < 4; l++) begin : g_lane
      for (g = 0; g < gact_pkg::S3_CELLS; g++) begin : g_s3
        gact_div_cell u_c (.clk, .rst_n, .en(adv), .lane_i(s3[l][g]),
                           .lane_o(s3[l][g+1]));
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].bearing     <= in_ch.bearing;
      side_r[0].drawn_width <= in_ch.drawn_width;
      side_r[0].advance     <= in_ch.advance;
      for (int k = 1; k < gact_pkg::SIDE_LEN; k++) side_r[k] <= side_r[k-1];
      sheet_r[0] <= s1[gact_pkg::S1_CELLS].num[15:0];
      for (int k = 1; k < gact_pkg::SHEET_LEN; k++) sheet_r[k] <= sheet_r[k-1];
    end
  end

  // Final sums and saturation.
  logic signed [gact_pkg::SUM_W-1:0] tx, tw, ty, th;
  always_comb begin
    tx = $signed({2'b00, s3[0][gact_pkg::S3_CELLS].num});
    tw = $signed({2'b00, s3[1][gact_pkg::S3_CELLS].num});
    ty = gact_pkg::ONE_FIX - $signed({2'b00, s3[2][gact_pkg::S3_CELLS].num});
    th = $signed({2'b00, s3[3][gact_pkg::S3_CELLS].num});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3[0][gact_pkg::S3_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.sheet_id    <= sheet_r[gact_pkg::SHEET_LEN-1];
      out_ch.x_offset    <= side_r[gact_pkg::SIDE_LEN-1].bearing;
      out_ch.image_width <= side_r[gact_pkg::SIDE_LEN-1].drawn_width;
      out_ch.pen_advance <= side_r[gact_pkg::SIDE_LEN-1].advance;
      out_ch.tex_left    <= gact_pkg::sat_tex(tx);
      out_ch.tex_top     <= gact_pkg::sat_tex(ty);
      out_ch.tex_right   <= gact_pkg::sat_tex(tx + tw);
      out_ch.tex_bottom  <= gact_pkg::sat_tex(ty - th);
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule
`default_nettype wire

// ----- rtl/gact_checker.sv -----
// ----------------------------------------------------------------------------
// gact_checker
// Port-level checks on the texcoord block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module gact_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_sheet_id,
  input wire logic [17:0] out_tex_left,
  input wire logic        cfg_pready
);
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_drain_opens: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sheet_id) && $stable(out_tex_left))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind glyph_atlas_cell_texcoords gact_checker u_gact_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_sheet_id(out_ch.sheet_id), .out_tex_left(out_ch.tex_left),
  .cfg_pready(cfg_pready)
);
`default_nettype wire

// ----- test/glyph_atlas_cell_texcoords_test.sv -----
// ----------------------------------------------------------------------------
// glyph_atlas_cell_texcoords_test
// Self-checking test of the glyph atlas texcoord block: a directed table, then
// random glyphs over several geometries, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module glyph_atlas_cell_texcoords_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 75;

  typedef struct packed {
    logic [15:0]        sheet_id;
    logic signed [7:0]  x_offset;
    logic [7:0]         image_width;
    logic signed [17:0] tex_left;
    logic signed [17:0] tex_top;
    logic signed [17:0] tex_right;
    logic signed [17:0] tex_bottom;
    logic [7:0]         pen_advance;
  } texcoord_t;

  typedef struct {
    logic [15:0] idx;
    logic [7:0]  bearing;
    logic [7:0]  dwidth;
    logic [7:0]  adv;
    bit          typed;
    texcoord_t   want;
  } glyph_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [gact_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  gact_in_if  in_ch();
  gact_out_if out_ch();

  glyph_atlas_cell_texcoords u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Local copy of the geometry registers.
  logic [15:0] g_per_sheet;
  logic [7:0]  g_per_line, g_cell_w, g_cell_h;
  logic [10:0] g_sheet_w, g_sheet_h;

  texcoord_t pending_q[$];
  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [17:0] clamp_tex(input longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic texcoord_t place_glyph(input logic [15:0] idx, input logic [7:0] bearing,
                                            input logic [7:0] dwidth, input logic [7:0] adv);
    longint ps, pl, sw, sh, sheet, rem, line, col, tx, ty, tw, th;
    texcoord_t r;
    ps = (g_per_sheet == 0) ? 1 : g_per_sheet;
    pl = (g_per_line == 0) ? 1 : g_per_line;
    sw = (g_sheet_w == 0) ? 1 : g_sheet_w;
    sh = (g_sheet_h == 0) ? 1 : g_sheet_h;
    sheet = idx / ps;
    rem = idx % ps;
    line = rem / pl;
    col = rem % pl;
    tx = ((col * (g_cell_w + 1) + 1) << gact_pkg::FRAC_BITS) / sw;
    ty = (longint'(1) << gact_pkg::FRAC_BITS)
         - (((line * (g_cell_h + 1) + 1) << gact_pkg::FRAC_BITS) / sh);
    tw = (longint'(dwidth) << gact_pkg::FRAC_BITS) / sw;
    th = (longint'(g_cell_h) << gact_pkg::FRAC_BITS) / sh;
    r.sheet_id = sheet[15:0];
    r.x_offset = bearing;
    r.image_width = dwidth;
    r.tex_left = clamp_tex(tx);
    r.tex_top = clamp_tex(ty);
    r.tex_right = clamp_tex(tx + tw);
    r.tex_bottom = clamp_tex(ty - th);
    r.pen_advance = adv;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= gact_pkg::ADDR_W'({idx, 2'b00}); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      gact_pkg::REG_PER_SHEET: g_per_sheet = val[15:0];
      gact_pkg::REG_PER_LINE:  g_per_line = val[7:0];
      gact_pkg::REG_CELL_W:    g_cell_w = val[7:0];
      gact_pkg::REG_CELL_H:    g_cell_h = val[7:0];
      gact_pkg::REG_SHEET_W:   g_sheet_w = val[10:0];
      gact_pkg::REG_SHEET_H:   g_sheet_h = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int ps, input int pl, input int cw, input int ch,
                              input int sw, input int sh);
    write_reg(gact_pkg::REG_PER_SHEET, ps);
    write_reg(gact_pkg::REG_PER_LINE, pl);
    write_reg(gact_pkg::REG_CELL_W, cw);
    write_reg(gact_pkg::REG_CELL_H, ch);
    write_reg(gact_pkg::REG_SHEET_W, sw);
    write_reg(gact_pkg::REG_SHEET_H, sh);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Bursty sender: random gaps between bursts of random length.
  int burst_left = 0;
  task automatic send_glyph(input logic [15:0] idx, input logic [7:0] bearing,
                            input logic [7:0] dwidth, input logic [7:0] adv);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end else begin
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.glyph_index <= idx; in_ch.bearing <= bearing;
    in_ch.drawn_width <= dwidth; in_ch.advance <= adv;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(place_glyph(idx, bearing, dwidth, adv));
    burst_left--;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver stalls in a pattern of its own, with free-running stretches.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 200) % 3 == 2) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 17 < 13);
  end

  always @(posedge clk) begin
    texcoord_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report("result transfer with none pending", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (out_ch.sheet_id !== w.sheet_id) report("sheet_id", out_ch.sheet_id, w.sheet_id);
        if (out_ch.x_offset !== w.x_offset) report("x_offset", out_ch.x_offset, w.x_offset);
        if (out_ch.image_width !== w.image_width)
          report("image_width", out_ch.image_width, w.image_width);
        if (out_ch.tex_left !== w.tex_left) report("tex_left", out_ch.tex_left, w.tex_left);
        if (out_ch.tex_top !== w.tex_top) report("tex_top", out_ch.tex_top, w.tex_top);
        if (out_ch.tex_right !== w.tex_right)
          report("tex_right", out_ch.tex_right, w.tex_right);
        if (out_ch.tex_bottom !== w.tex_bottom)
          report("tex_bottom", out_ch.tex_bottom, w.tex_bottom);
        if (out_ch.pen_advance !== w.pen_advance)
          report("pen_advance", out_ch.pen_advance, w.pen_advance);
      end
    end
  end

  function automatic glyph_row_t row(input int idx, input int b, input int dw, input int adv);
    glyph_row_t r;
    r.idx = 16'(idx); r.bearing = 8'(b); r.dwidth = 8'(dw); r.adv = 8'(adv);
    r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  glyph_row_t directed_rows[$];
  texcoord_t  w_typed;

  initial begin
    glyph_row_t r;
    int geo;
    int hi;
    in_ch.valid = 1'b0;
    in_ch.glyph_index = '0; in_ch.bearing = '0; in_ch.drawn_width = '0; in_ch.advance = '0;
    g_per_sheet = 16'd1; g_per_line = 8'd1; g_cell_w = 8'd0; g_cell_h = 8'd0;
    g_sheet_w = 11'd256; g_sheet_h = 11'd256;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // After reset every glyph is alone on its sheet: left 1/256, top 1-1/256.
    r = row(16'hFFFF, -128, 255, 255);
    r.typed = 1'b1;
    r.want = '{16'hFFFF, -8'sd128, 8'd255, 18'sd256, 18'sd65280, 18'sd65536, 18'sd65280, 8'd255};
    directed_rows.push_back(r);
    r = row(0, 127, 0, 0);
    r.typed = 1'b1;
    r.want = '{16'd0, 8'sd127, 8'd0, 18'sd256, 18'sd65280, 18'sd256, 18'sd65280, 8'd0};
    directed_rows.push_back(r);
    foreach (directed_rows[i]) begin
      send_glyph(directed_rows[i].idx, directed_rows[i].bearing,
                 directed_rows[i].dwidth, directed_rows[i].adv);
      w_typed = pending_q[$];
      if (w_typed !== directed_rows[i].want) report("typed row", i, i);
    end
    stop_sending();
    drain();

    // A sheet of one texel drives the right and bottom edges into saturation,
    // and zero counts and sizes stand for one.
    directed_rows.delete();
    directed_rows.push_back(row(16'hFFFF, 5, 255, 1));
    directed_rows.push_back(row(1234, -1, 128, 2));
    set_geometry(0, 0, 255, 255, 1, 0);
    foreach (directed_rows[i])
      send_glyph(directed_rows[i].idx, directed_rows[i].bearing,
                 directed_rows[i].dwidth, directed_rows[i].adv);
    stop_sending();
    drain();

    // Largest cells with many per line: far cells run off the sheet.
    set_geometry(65535, 255, 255, 255, 1024, 1024);
    directed_rows.delete();
    directed_rows.push_back(row(0, 0, 0, 0));
    directed_rows.push_back(row(254, 1, 255, 3));
    directed_rows.push_back(row(255, 2, 17, 4));
    directed_rows.push_back(row(65534, -7, 200, 9));
    directed_rows.push_back(row(65535, -128, 255, 255));
    // Sheet sizes above the nominal range are used as given.
    foreach (directed_rows[i])
      send_glyph(directed_rows[i].idx, directed_rows[i].bearing,
                 directed_rows[i].dwidth, directed_rows[i].adv);
    stop_sending();
    drain();
    set_geometry(100, 10, 7, 9, 2047, 2047);
    foreach (directed_rows[i])
      send_glyph(directed_rows[i].idx, directed_rows[i].bearing,
                 directed_rows[i].dwidth, directed_rows[i].adv);
    stop_sending();
    drain();

    for (geo = 0; geo < 6; geo++) begin
      if (geo == 5) set_geometry(65535, 255, 0, 0, 1024, 1024);
      else set_geometry($urandom_range(1, 4096), $urandom_range(1, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(1, 1024), $urandom_range(1, 1024));
      hi = (4 * int'(g_per_sheet) > 65535) ? 65535 : 4 * int'(g_per_sheet);
      repeat (125) begin
        if ($urandom_range(0, 3) == 0)
          send_glyph(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_glyph(16'($urandom_range(0, hi)),
                     8'($urandom), 8'($urandom), 8'($urandom));
      end
      stop_sending();
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- glyph_atlas_cell_texcoords.f -----
rtl/gact_pkg.sv
rtl/gact_if.sv
rtl/gact_div_cell.sv
rtl/gact_cfg_regs.sv
rtl/glyph_atlas_cell_texcoords.sv
rtl/gact_checker.sv
test/glyph_atlas_cell_texcoords_test.sv
